[hdl/stk_pkg.sv]
`timescale 1ns / 1ps

package stk_pkg;

  localparam int POS_WIDTH  = 16;
  localparam int LINE_WIDTH = 16;
  localparam int MODE_W     = 4;
  localparam int LEN_MAX    = 65535;

  // token kinds
  localparam logic [4:0] K_IDENT   = 5'd0;
  localparam logic [4:0] K_INT     = 5'd1;
  localparam logic [4:0] K_FLOAT   = 5'd2;
  localparam logic [4:0] K_CHAR    = 5'd3;
  localparam logic [4:0] K_AMP     = 5'd4;
  localparam logic [4:0] K_CARET   = 5'd5;
  localparam logic [4:0] K_BAR     = 5'd6;
  localparam logic [4:0] K_PLUS    = 5'd7;
  localparam logic [4:0] K_MINUS   = 5'd8;
  localparam logic [4:0] K_STAR    = 5'd9;
  localparam logic [4:0] K_SLASH   = 5'd10;
  localparam logic [4:0] K_PERCENT = 5'd11;
  localparam logic [4:0] K_EQUAL   = 5'd12;
  localparam logic [4:0] K_ASSIGN  = 5'd13;
  localparam logic [4:0] K_LSHIFT  = 5'd14;
  localparam logic [4:0] K_LE      = 5'd15;
  localparam logic [4:0] K_LT      = 5'd16;
  localparam logic [4:0] K_RSHIFT  = 5'd17;
  localparam logic [4:0] K_GE      = 5'd18;
  localparam logic [4:0] K_GT      = 5'd19;
  localparam logic [4:0] K_NE      = 5'd20;
  localparam logic [4:0] K_TILDE   = 5'd21;
  localparam logic [4:0] K_LPAREN  = 5'd22;
  localparam logic [4:0] K_RPAREN  = 5'd23;
  localparam logic [4:0] K_LBRACK  = 5'd24;
  localparam logic [4:0] K_RBRACK  = 5'd25;
  localparam logic [4:0] K_DOT     = 5'd26;
  localparam logic [4:0] K_COMMA   = 5'd27;
  localparam logic [4:0] K_COLON   = 5'd28;
  localparam logic [4:0] K_SEMI    = 5'd29;
  localparam logic [4:0] K_ERROR   = 5'd30;
  localparam logic [4:0] K_EOF     = 5'd31;

  // scanner modes
  localparam logic [MODE_W-1:0] M_START = 4'd0;
  localparam logic [MODE_W-1:0] M_IDENT = 4'd1;
  localparam logic [MODE_W-1:0] M_INT   = 4'd2;
  localparam logic [MODE_W-1:0] M_FRAC  = 4'd3;
  localparam logic [MODE_W-1:0] M_CHAR1 = 4'd4;
  localparam logic [MODE_W-1:0] M_CHAR2 = 4'd5;
  localparam logic [MODE_W-1:0] M_DONE  = 4'd6;
  localparam logic [MODE_W-1:0] M_SLASH = 4'd7;
  localparam logic [MODE_W-1:0] M_LINE  = 4'd8;
  localparam logic [MODE_W-1:0] M_BLOCK = 4'd9;
  localparam logic [MODE_W-1:0] M_BSTAR = 4'd10;
  localparam logic [MODE_W-1:0] M_EQ    = 4'd11;
  localparam logic [MODE_W-1:0] M_LT    = 4'd12;
  localparam logic [MODE_W-1:0] M_GT    = 4'd13;
  localparam logic [MODE_W-1:0] M_BANG  = 4'd14;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
  } stk_in_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [7:0]  char_value;
    logic        bad_quote;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic        last;
  } stk_out_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

[hdl/source_tokenizer_core.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+------------------------------
// in_      | input     | in_valid/in_stall | stk_in_t  {op, byte_in}
// out_     | output    | out_valid/out_stall | stk_out_t (one token)
//
// One byte or end marker is taken every cycle while in_stall is low; its
// tokens land in a four-entry result queue at the edge that accepts it, whose
// head drives out_; the queue drains one token a cycle while out_stall is low.
// rst_n is synchronous, active low; it clears the scanner and the queue.
// in_stall rises when fewer than two queue slots are free, since an end
// marker can produce two tokens (flushed token plus end-of-file).
// out_stall holds the head token in place; the queue keeps filling behind it.
module source_tokenizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stk_pkg::stk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stk_pkg::stk_out_t out_data
);
  import stk_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [POS_WIDTH-1:0]  POS_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

  // scanner state
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [4:0]            pkind_r, pkind_nxt;
  logic [POS_WIDTH-1:0]  tbegin_r, tbegin_nxt;
  logic [POS_WIDTH-1:0]  bpos_r, bpos_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;
  logic [LINE_WIDTH-1:0] col_r, col_nxt;
  logic [7:0]            hchar_r, hchar_nxt;
  logic                  first_r, first_nxt;
  logic                  hbad_r, hbad_nxt;

  // result queue
  stk_out_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                  in_xfer, out_xfer;
  logic [1:0]            n_res;
  stk_out_t              res0, res1;

  // pending token of the current mode
  logic                  pend_vld;
  logic [4:0]            pend_kind;
  logic [7:0]            pend_cv;
  logic                  pend_bad;

  logic [7:0]            b;
  logic                  consumed;
  logic [POS_WIDTH-1:0]  len_raw;
  logic [15:0]           len_sat;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = cnt_r > Q_CNT_W'(Q_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_ptr_r];
  assign b = in_data.byte_in;

  always_comb begin
    pend_vld  = 1'b1;
    pend_kind = K_IDENT;
    pend_cv   = 8'd0;
    pend_bad  = 1'b0;
    unique case (mode_r)
      M_IDENT: pend_kind = K_IDENT;
      M_INT:   pend_kind = K_INT;
      M_FRAC:  pend_kind = K_FLOAT;
      M_CHAR1: begin
        pend_kind = K_CHAR;
        pend_bad  = 1'b1;
      end
      M_CHAR2: begin
        pend_kind = K_CHAR;
        pend_cv   = hchar_r;
        pend_bad  = 1'b1;
      end
      M_DONE: begin
        pend_kind = pkind_r;
        pend_cv   = hchar_r;
        pend_bad  = hbad_r;
      end
      M_SLASH: pend_kind = K_SLASH;
      M_EQ:    pend_kind = K_ASSIGN;
      M_LT:    pend_kind = K_LT;
      M_GT:    pend_kind = K_GT;
      M_BANG: begin
        pend_kind = K_ERROR;
        pend_cv   = CH_BANG;
      end
      default: pend_vld = 1'b0;
    endcase
  end

  // Token length: the current position (end marker) or the lookahead's
  // offset, minus the token start; never negative since both only grow.
  always_comb begin
    len_raw = (in_data.op == OP_END) ? (bpos_r - tbegin_r) : (bpos_r - tbegin_r);
    len_sat = (32'(len_raw) > 32'(LEN_MAX)) ? 16'(LEN_MAX) : 16'(len_raw);
  end

  always_comb begin
    mode_nxt   = mode_r;
    pkind_nxt  = pkind_r;
    tbegin_nxt = tbegin_r;
    bpos_nxt   = bpos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    hchar_nxt  = hchar_r;
    first_nxt  = first_r;
    hbad_nxt   = hbad_r;
    consumed   = 1'b1;
    n_res      = 2'd0;

    res0.kind       = pend_kind;
    res0.start_res  = 16'(tbegin_r);
    res0.length     = len_sat;
    res0.char_value = pend_cv;
    res0.bad_quote  = pend_bad;
    res0.line_no    = 16'(line_r);
    res0.col_no     = 16'(col_r);
    res0.last       = 1'b0;

    res1.kind       = K_EOF;
    res1.start_res  = 16'(bpos_r);
    res1.length     = 16'd0;
    res1.char_value = 8'd0;
    res1.bad_quote  = 1'b0;
    res1.line_no    = 16'(line_r);
    res1.col_no     = 16'(col_r);
    res1.last       = 1'b1;

    if (in_data.op == OP_END) begin
      // flush, then end-of-file; the scanner returns to its reset state
      if (pend_vld) begin
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
        res0  = res1;
      end
      mode_nxt   = M_START;
      pkind_nxt  = K_IDENT;
      tbegin_nxt = '0;
      bpos_nxt   = '0;
      line_nxt   = LINE_WIDTH'(1);
      col_nxt    = LINE_WIDTH'(1);
      hchar_nxt  = 8'd0;
      first_nxt  = 1'b1;
      hbad_nxt   = 1'b0;
    end else begin
      // cursor moves to this byte (CR leaves it in place); the first byte of a run stays at 1:1
      if (!first_r && b != CH_CR) begin
        if (b == CH_LF) begin
          col_nxt = LINE_WIDTH'(1);
          if (line_r < LINE_MAX) line_nxt = line_r + LINE_WIDTH'(1);
        end else if (col_r < LINE_MAX) begin
          col_nxt = col_r + LINE_WIDTH'(1);
        end
      end
      first_nxt = 1'b0;
      if (bpos_r < POS_MAX) bpos_nxt = bpos_r + POS_WIDTH'(1);

      unique case (mode_r)
        M_IDENT: if (!(is_alpha(b) || is_digit(b) || b == CH_UNDER)) consumed = 1'b0;
        M_INT: begin
          if (b == CH_DOT) mode_nxt = M_FRAC;
          else if (!is_digit(b)) consumed = 1'b0;
        end
        M_FRAC:  if (!is_digit(b)) consumed = 1'b0;
        M_CHAR1: begin
          hchar_nxt = b;
          mode_nxt  = M_CHAR2;
        end
        M_CHAR2: begin
          hbad_nxt  = (b != CH_QUOTE);
          pkind_nxt = K_CHAR;
          mode_nxt  = M_DONE;
        end
        M_SLASH: begin
          if (b == CH_SLASH) mode_nxt = M_LINE;
          else if (b == CH_STAR) mode_nxt = M_BLOCK;
          else consumed = 1'b0;
        end
        M_LINE:  if (b == CH_LF) mode_nxt = M_START;
        M_BLOCK: if (b == CH_STAR) mode_nxt = M_BSTAR;
        M_BSTAR: begin
          if (b == CH_SLASH) mode_nxt = M_START;
          else if (b != CH_STAR) mode_nxt = M_BLOCK;
        end
        M_EQ: begin
          if (b == CH_EQ) begin
            pkind_nxt = K_EQUAL;
            mode_nxt  = M_DONE;
          end else begin
            consumed = 1'b0;
          end
        end
        M_LT: begin
          if (b == CH_LT) begin
            pkind_nxt = K_LSHIFT;
            mode_nxt  = M_DONE;
          end else if (b == CH_EQ) begin
            pkind_nxt = K_LE;
            mode_nxt  = M_DONE;
          end else begin
            consumed = 1'b0;
          end
        end
        M_GT: begin
          if (b == CH_GT) begin
            pkind_nxt = K_RSHIFT;
            mode_nxt  = M_DONE;
          end else if (b == CH_EQ) begin
            pkind_nxt = K_GE;
            mode_nxt  = M_DONE;
          end else begin
            consumed = 1'b0;
          end
        end
        M_BANG: begin
          if (b == CH_EQ) begin
            pkind_nxt = K_NE;
            mode_nxt  = M_DONE;
          end else begin
            consumed = 1'b0;
          end
        end
        default: consumed = 1'b0;
      endcase

      if (!consumed) begin
        // this byte is the lookahead: emit what was pending, then start anew
        res0.line_no = 16'(line_nxt);
        res0.col_no  = 16'(col_nxt);
        n_res        = pend_vld ? 2'd1 : 2'd0;
        tbegin_nxt   = bpos_r;
        hchar_nxt    = 8'd0;
        hbad_nxt     = 1'b0;
        mode_nxt     = M_START;
        if (b == CH_CR || b == CH_LF || b == CH_TAB || b == CH_FF ||
            b == CH_VT || b == CH_SPACE) begin
          mode_nxt = M_START;
        end else if (is_alpha(b)) begin
          mode_nxt = M_IDENT;
        end else if (is_digit(b)) begin
          mode_nxt = M_INT;
        end else begin
          mode_nxt = M_DONE;
          case (b)
            CH_QUOTE: mode_nxt  = M_CHAR1;
            CH_SLASH: mode_nxt  = M_SLASH;
            CH_EQ:    mode_nxt  = M_EQ;
            CH_LT:    mode_nxt  = M_LT;
            CH_GT:    mode_nxt  = M_GT;
            CH_BANG:  mode_nxt  = M_BANG;
            CH_AMP:   pkind_nxt = K_AMP;
            CH_CARET: pkind_nxt = K_CARET;
            CH_BAR:   pkind_nxt = K_BAR;
            CH_PLUS:  pkind_nxt = K_PLUS;
            CH_MINUS: pkind_nxt = K_MINUS;
            CH_STAR:  pkind_nxt = K_STAR;
            CH_PCT:   pkind_nxt = K_PERCENT;
            CH_TILDE: pkind_nxt = K_TILDE;
            CH_LPAR:  pkind_nxt = K_LPAREN;
            CH_RPAR:  pkind_nxt = K_RPAREN;
            CH_LBRK:  pkind_nxt = K_LBRACK;
            CH_RBRK:  pkind_nxt = K_RBRACK;
            CH_DOT:   pkind_nxt = K_DOT;
            CH_COMMA: pkind_nxt = K_COMMA;
            CH_COLON: pkind_nxt = K_COLON;
            CH_SEMI:  pkind_nxt = K_SEMI;
            default: begin
              // unknown byte: error token carrying the byte
              hchar_nxt = b;
              pkind_nxt = K_ERROR;
            end
          endcase
        end
      end
    end
  end

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_xfer) begin
      wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(n_res);
      cnt_nxt    = cnt_nxt + Q_CNT_W'(n_res);
    end
    if (out_xfer) begin
      rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(1);
      cnt_nxt    = cnt_nxt - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      pkind_r  <= K_IDENT;
      tbegin_r <= '0;
      bpos_r   <= '0;
      line_r   <= LINE_WIDTH'(1);
      col_r    <= LINE_WIDTH'(1);
      hchar_r  <= 8'd0;
      first_r  <= 1'b1;
      hbad_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_xfer) begin
        mode_r   <= mode_nxt;
        pkind_r  <= pkind_nxt;
        tbegin_r <= tbegin_nxt;
        bpos_r   <= bpos_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        hchar_r  <= hchar_nxt;
        first_r  <= first_nxt;
        hbad_r   <= hbad_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (n_res != 2'd0) q_r[wr_ptr_r] <= res0;
      if (n_res == 2'd2) q_r[wr_ptr_r + Q_PTR_W'(1)] <= res1;
    end
  end

  // fill count stays within the queue
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // the token start never runs ahead of the byte count
  a_begin_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tbegin_r <= bpos_r)
    else $error("token start beyond byte count");

  // an end marker leaves the scanner in its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.op == OP_END |=>
      mode_r == M_START && bpos_r == '0 && first_r && line_r == LINE_WIDTH'(1))
    else $error("scanner not reset after end marker");

  // an end marker always queues a token
  a_end_queues: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.op == OP_END |=> out_valid)
    else $error("end marker produced no token");

  // queue pointers and count agree
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    Q_PTR_W'(rd_ptr_r + Q_PTR_W'(cnt_r)) == wr_ptr_r)
    else $error("queue pointers out of step with count");

endmodule

[dv/tb_source_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_source_tokenizer_core;
  import stk_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int TAIL        = 8;     // cycles allowed after the last due token
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS = 250;
  localparam int DIR_ROWS    = 26;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  stk_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stk_out_t out_data;

  source_tokenizer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // pacing knobs, written by the stimulus process, except holds_done, which the receiver counts
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  int err_count = 0;
  int tok_seen  = 0;
  int quiet     = 0;

  stk_out_t tokens_due [$];   // tokens the scanner model says are owed
  stk_in_t  src_q      [$];   // generated source text waiting to be sent

  // ---------------------------------------------------------------------
  // Scanner model: mirrors the lexer one byte at a time
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0] lx_mode;
  logic [4:0]        lx_kind;    // kind of a finished token in M_DONE
  logic [15:0]       lx_begin;
  logic [15:0]       lx_pos;
  logic [15:0]       lx_line;
  logic [15:0]       lx_col;
  logic [7:0]        lx_held;
  logic              lx_first;
  logic              lx_bad;

  function automatic void lexer_reset();
    lx_mode  = M_START;
    lx_kind  = K_IDENT;
    lx_begin = '0;
    lx_pos   = '0;
    lx_line  = 16'd1;
    lx_col   = 16'd1;
    lx_held  = '0;
    lx_first = 1'b1;
    lx_bad   = 1'b0;
  endfunction

  function automatic logic letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void op_done(input logic [4:0] k);
    lx_kind = k;
    lx_mode = M_DONE;
  endfunction

  // token built from the current begin offset and cursor
  function automatic stk_out_t make_token(input logic [4:0] kind, input logic [15:0] len,
                                          input logic [7:0] cv, input logic bad,
                                          input logic last);
    stk_out_t t;
    t.kind       = kind;
    t.start_res  = lx_begin;
    t.length     = len;
    t.char_value = cv;
    t.bad_quote  = bad;
    t.line_no    = lx_line;
    t.col_no     = lx_col;
    t.last       = last;
    return t;
  endfunction

  // token owed by the current mode, if any
  function automatic bit pending_token(output logic [4:0] kind, output logic [7:0] cv,
                                       output logic bad);
    kind = K_IDENT;
    cv   = '0;
    bad  = 1'b0;
    case (lx_mode)
      M_IDENT: kind = K_IDENT;
      M_INT:   kind = K_INT;
      M_FRAC:  kind = K_FLOAT;
      M_CHAR1: begin
        kind = K_CHAR;
        bad  = 1'b1;
      end
      M_CHAR2: begin
        kind = K_CHAR;
        cv   = lx_held;
        bad  = 1'b1;
      end
      M_DONE: begin
        kind = lx_kind;
        cv   = lx_held;
        bad  = lx_bad;
      end
      M_SLASH: kind = K_SLASH;
      M_EQ:    kind = K_ASSIGN;
      M_LT:    kind = K_LT;
      M_GT:    kind = K_GT;
      M_BANG: begin
        kind = K_ERROR;
        cv   = CH_BANG;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advance the model by one input transfer; returns how many tokens it owes.
  function automatic int scan_byte(input stk_in_t it, output stk_out_t t0,
                                   output stk_out_t t1);
    stk_out_t    r [2];
    logic [7:0]  b;
    logic [4:0]  k;
    logic [7:0]  cv;
    logic        bad;
    logic [15:0] pos;
    logic        used;
    int          n;
    b    = it.byte_in;
    n    = 0;
    used = 1'b1;
    r[0] = '0;
    r[1] = '0;
    if (it.op == OP_END) begin
      // flush, then end of file; the scanner starts over afterwards
      if (pending_token(k, cv, bad)) begin
        r[n] = make_token(k, lx_pos - lx_begin, cv, bad, 1'b0);
        n++;
      end
      lx_begin = lx_pos;
      r[n] = make_token(K_EOF, 16'd0, 8'd0, 1'b0, 1'b1);
      n++;
      lexer_reset();
    end else begin
      // cursor: first byte does not move it, CR never does
      if (!lx_first && b != CH_CR) begin
        if (b == CH_LF) begin
          lx_col = 16'd1;
          if (lx_line != '1) lx_line++;
        end else if (lx_col != '1) begin
          lx_col++;
        end
      end
      lx_first = 1'b0;
      pos = lx_pos;
      if (lx_pos != '1) lx_pos++;

      case (lx_mode)
        M_IDENT: used = letter(b) || digit(b) || b == CH_UNDER;
        M_INT: begin
          if (b == CH_DOT) lx_mode = M_FRAC;
          else used = digit(b);
        end
        M_FRAC: used = digit(b);
        M_CHAR1: begin
          lx_held = b;
          lx_mode = M_CHAR2;
        end
        M_CHAR2: begin
          // closing byte is eaten whatever it is
          lx_bad = (b != CH_QUOTE);
          op_done(K_CHAR);
        end
        M_SLASH: begin
          if (b == CH_SLASH) lx_mode = M_LINE;
          else if (b == CH_STAR) lx_mode = M_BLOCK;
          else used = 1'b0;
        end
        M_LINE:  if (b == CH_LF) lx_mode = M_START;
        M_BLOCK: if (b == CH_STAR) lx_mode = M_BSTAR;
        M_BSTAR: begin
          if (b == CH_SLASH) lx_mode = M_START;
          else if (b != CH_STAR) lx_mode = M_BLOCK;
        end
        M_EQ: begin
          if (b == CH_EQ) op_done(K_EQUAL);
          else used = 1'b0;
        end
        M_LT: begin
          if (b == CH_LT) op_done(K_LSHIFT);
          else if (b == CH_EQ) op_done(K_LE);
          else used = 1'b0;
        end
        M_GT: begin
          if (b == CH_GT) op_done(K_RSHIFT);
          else if (b == CH_EQ) op_done(K_GE);
          else used = 1'b0;
        end
        M_BANG: begin
          if (b == CH_EQ) op_done(K_NE);
          else used = 1'b0;
        end
        default: used = 1'b0;
      endcase

      if (!used) begin
        // byte is lookahead: emit what is pending, then start on this byte
        if (pending_token(k, cv, bad)) begin
          r[n] = make_token(k, pos - lx_begin, cv, bad, 1'b0);
          n++;
        end
        lx_begin = pos;
        lx_held  = '0;
        lx_bad   = 1'b0;
        lx_mode  = M_START;
        if (letter(b)) lx_mode = M_IDENT;
        else if (digit(b)) lx_mode = M_INT;
        else begin
          case (b) inside
            CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE: ;
            CH_QUOTE: lx_mode = M_CHAR1;
            CH_SLASH: lx_mode = M_SLASH;
            CH_EQ:    lx_mode = M_EQ;
            CH_LT:    lx_mode = M_LT;
            CH_GT:    lx_mode = M_GT;
            CH_BANG:  lx_mode = M_BANG;
            CH_AMP:   op_done(K_AMP);
            CH_CARET: op_done(K_CARET);
            CH_BAR:   op_done(K_BAR);
            CH_PLUS:  op_done(K_PLUS);
            CH_MINUS: op_done(K_MINUS);
            CH_STAR:  op_done(K_STAR);
            CH_PCT:   op_done(K_PERCENT);
            CH_TILDE: op_done(K_TILDE);
            CH_LPAR:  op_done(K_LPAREN);
            CH_RPAR:  op_done(K_RPAREN);
            CH_LBRK:  op_done(K_LBRACK);
            CH_RBRK:  op_done(K_RBRACK);
            CH_DOT:   op_done(K_DOT);
            CH_COMMA: op_done(K_COMMA);
            CH_COLON: op_done(K_COLON);
            CH_SEMI:  op_done(K_SEMI);
            default: begin
              lx_held = b;
              op_done(K_ERROR);
            end
          endcase
        end
      end
    end
    t0 = r[0];
    t1 = r[1];
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic stk_in_t byte_item(input logic [7:0] b);
    stk_in_t it;
    it.op      = OP_BYTE;
    it.byte_in = b;
    return it;
  endfunction

  function automatic stk_in_t end_item(input logic [7:0] junk);
    stk_in_t it;
    it.op      = OP_END;
    it.byte_in = junk;   // ignored by the block
    return it;
  endfunction

  function automatic stk_out_t mk_tok(input logic [4:0] kind, input int start,
                                      input int len, input int cv,
                                      input int bad, input int line,
                                      input int col, input int last);
    stk_out_t t;
    t.kind       = kind;
    t.start_res  = 16'(start);
    t.length     = 16'(len);
    t.char_value = 8'(cv);
    t.bad_quote  = 1'(bad);
    t.line_no    = 16'(line);
    t.col_no     = 16'(col);
    t.last       = 1'(last);
    return t;
  endfunction

  function automatic void owe_token(input stk_out_t t);
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void put(input logic [7:0] b);
    src_q.insert(src_q.size(), byte_item(b));
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    return CH_UNDER;
  endfunction

  // one input transfer; sender gaps are drawn per cycle
  task automatic transfer_in(input stk_in_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input stk_in_t it);
    stk_out_t t0, t1;
    int       n;
    transfer_in(it);
    n = scan_byte(it, t0, t1);
    if (n > 0) owe_token(t0);
    if (n > 1) owe_token(t1);
  endtask

  // sender goes quiet until every owed token has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Random phase: mostly well-formed lexemes with random content, plus noise
  // bytes, unterminated char literals and end markers dropped in between lexemes.
  task automatic run_phase(input int items, input int idle, input int stall,
                           input bit hold);
    logic [7:0] ws_chars [6];
    logic [7:0] op_chars [21];
    logic [7:0] pair_2nd [3];
    int sent;
    int pick;
    ws_chars = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
    op_chars = '{CH_AMP, CH_CARET, CH_BAR, CH_PLUS, CH_MINUS, CH_STAR, CH_PCT,
                 CH_TILDE, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_DOT, CH_COMMA,
                 CH_COLON, CH_SEMI, CH_SLASH, CH_EQ, CH_LT, CH_GT, CH_BANG};
    pair_2nd = '{CH_EQ, CH_LT, CH_GT};
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_requests++;   // receiver runs the hold-off on its own
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        // identifier
        put("a" + 8'($urandom_range(25)));
        repeat ($urandom_range(7)) put(word_char());
      end else if (pick < 34) begin
        // integer, sometimes with a fraction
        repeat ($urandom_range(1, 5)) put("0" + 8'($urandom_range(9)));
        if ($urandom_range(9) < 3) begin
          put(CH_DOT);
          repeat ($urandom_range(3)) put("0" + 8'($urandom_range(9)));
        end
      end else if (pick < 40) begin
        // char literal, closing quote missing now and then
        put(CH_QUOTE);
        put(8'($urandom_range(255)));
        put(($urandom_range(99) < 85) ? CH_QUOTE : 8'($urandom_range(255)));
      end else if (pick < 52) begin
        put(op_chars[$urandom_range(20)]);
      end else if (pick < 62) begin
        // two-character operator candidates: ==, <<, <=, >>, >=, != and near misses
        case ($urandom_range(3))
          0: put(CH_EQ);
          1: put(CH_LT);
          2: put(CH_GT);
          default: put(CH_BANG);
        endcase
        put(pair_2nd[$urandom_range(2)]);
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 3)) put(ws_chars[$urandom_range(5)]);
      end else if (pick < 83) begin
        put(CH_SLASH);
        if ($urandom_range(1) == 0) begin
          put(CH_SLASH);
          repeat ($urandom_range(6)) put(8'($urandom_range(255)));
          put(CH_LF);
        end else begin
          put(CH_STAR);
          repeat ($urandom_range(6)) begin
            case ($urandom_range(2))
              0: put(CH_STAR);
              1: put(CH_SLASH);
              default: put(8'($urandom_range(32, 126)));
            endcase
          end
          repeat ($urandom_range(1, 2)) put(CH_STAR);
          put(CH_SLASH);
        end
      end else if (pick < 95) begin
        put(8'($urandom_range(255)));
      end else begin
        src_q.insert(src_q.size(), end_item(8'($urandom_range(255))));
      end
      while (src_q.size() != 0) begin
        feed(src_q.pop_front());
        sent++;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall per cycle, plus a counted hold-off on request
  // ---------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH token %0d: %s", tok_seen, what);
  endtask

  // ---------------------------------------------------------------------
  // Result check: every output transfer against the oldest owed token
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : token_check
    stk_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("token with none due, kind %0d", out_data.kind));
      end else begin
        want = tokens_due.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d want %0d", out_data.kind, want.kind));
        if (out_data.start_res !== want.start_res)
          report_mismatch($sformatf("start %0d want %0d", out_data.start_res,
                                    want.start_res));
        if (out_data.length !== want.length)
          report_mismatch($sformatf("length %0d want %0d", out_data.length, want.length));
        if (out_data.char_value !== want.char_value)
          report_mismatch($sformatf("char %0h want %0h", out_data.char_value,
                                    want.char_value));
        if (out_data.bad_quote !== want.bad_quote)
          report_mismatch($sformatf("bad_quote %0b want %0b", out_data.bad_quote,
                                    want.bad_quote));
        if (out_data.line_no !== want.line_no)
          report_mismatch($sformatf("line %0d want %0d", out_data.line_no, want.line_no));
        if (out_data.col_no !== want.col_no)
          report_mismatch($sformatf("col %0d want %0d", out_data.col_no, want.col_no));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0b want %0b", out_data.last, want.last));
      end
      tok_seen++;
    end
  end

  // watchdog: too long without a transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("source_tokenizer_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed rows: typed token where it is obvious, else the model decides
  // ---------------------------------------------------------------------
  typedef struct {
    stk_in_t  item;
    bit       typed;
    stk_out_t tok;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  initial begin : stimulus
    stk_out_t t0, t1;
    int       n;

    dir_tab = '{
      // first byte leaves the cursor at 1:1
      '{byte_item("a"),      1'b0, '0},
      '{byte_item(CH_PLUS),  1'b1, mk_tok(K_IDENT, 0, 1, 0, 0, 1, 2, 0)},
      '{byte_item(CH_BANG),  1'b1, mk_tok(K_PLUS, 1, 1, 0, 0, 1, 3, 0)},
      // lone bang is an error token, next byte scanned normally
      '{byte_item("x"),      1'b1, mk_tok(K_ERROR, 2, 1, CH_BANG, 0, 1, 4, 0)},
      // null byte is just an unknown byte
      '{byte_item(8'h00),    1'b1, mk_tok(K_IDENT, 3, 1, 0, 0, 1, 5, 0)},
      '{byte_item(8'hff),    1'b1, mk_tok(K_ERROR, 4, 1, 8'h00, 0, 1, 6, 0)},
      '{byte_item(CH_QUOTE), 1'b1, mk_tok(K_ERROR, 5, 1, 8'hff, 0, 1, 7, 0)},
      // char literal whose closing byte is not a quote
      '{byte_item("q"),      1'b0, '0},
      '{byte_item("z"),      1'b0, '0},
      '{byte_item(CH_LF),    1'b1, mk_tok(K_CHAR, 6, 3, "q", 1, 2, 1, 0)},
      // float, then a block comment with CR and a double star
      '{byte_item("1"),      1'b0, '0},
      '{byte_item(CH_DOT),   1'b0, '0},
      '{byte_item("9"),      1'b0, '0},
      '{byte_item(CH_SLASH), 1'b0, '0},
      '{byte_item(CH_STAR),  1'b0, '0},
      '{byte_item(CH_CR),    1'b0, '0},
      '{byte_item(CH_STAR),  1'b0, '0},
      '{byte_item(CH_STAR),  1'b0, '0},
      '{byte_item(CH_SLASH), 1'b0, '0},
      // end right after an opening quote: char with value 0, then EOF
      '{byte_item(CH_QUOTE), 1'b0, '0},
      '{end_item(8'ha5),     1'b0, '0},
      // end on an empty buffer
      '{end_item(8'hff),     1'b1, mk_tok(K_EOF, 0, 0, 0, 0, 1, 1, 1)},
      // end inside a line comment: only EOF
      '{byte_item(CH_SLASH), 1'b0, '0},
      '{byte_item(CH_SLASH), 1'b0, '0},
      '{byte_item(8'hff),    1'b0, '0},
      '{end_item(8'h00),     1'b1, mk_tok(K_EOF, 3, 0, 0, 0, 1, 3, 1)}
    };

    lexer_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      transfer_in(dir_tab[i].item);
      n = scan_byte(dir_tab[i].item, t0, t1);
      if (dir_tab[i].typed) begin
        owe_token(dir_tab[i].tok);
      end else begin
        if (n > 0) owe_token(t0);
        if (n > 1) owe_token(t1);
      end
    end
    drain();

    run_phase(PHASE_ITEMS, 0, 0, 1'b0);
    run_phase(PHASE_ITEMS, 66, 0, 1'b0);
    run_phase(PHASE_ITEMS, 0, 66, 1'b0);
    run_phase(PHASE_ITEMS, 16, 16, 1'b0);
    // receiver holds off while bytes keep coming: queue fills, input stalls
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);

    if (err_count == 0) $display("source_tokenizer_core verification clean");
    else $display("source_tokenizer_core verification failed");
    $finish;
  end

endmodule
